/* rtl/core/cblf_pkg.sv */
// Package: shared types, constants and functions for the circle boundary link fraction unit
`timescale 1ns / 1ps
package cblf_pkg;
	localparam int FRAC_BITS_DEF   = 16;
	localparam int COORD_LIMIT_DEF = 1024;
	localparam int CW  = 12;
	localparam int OW  = 14;
	localparam int FW  = 17;
	localparam int DW  = 4;
	localparam int NNB = 8;

	typedef enum logic [1:0] {
		REG_RADIUS   = 2'd0,
		REG_CENTER_X = 2'd1,
		REG_CENTER_Y = 2'd2,
		REG_ADD_CTR  = 2'd3
	} reg_idx_t;

	// one neighbor link, as handed from link generation to the fraction pipeline
	typedef struct packed {
		logic [DW-1:0]        dir;
		logic [DW-1:0]        back;
		logic signed [1:0]    di;
		logic signed [1:0]    dj;
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic [OW-1:0]        ox;
		logic [OW-1:0]        oy;
		logic [24:0]          c;
		logic                 last;
	} link_t;

	function automatic logic [DW-1:0] nb_dir(input logic [2:0] k);
		logic [DW-1:0] r;
		case (k)
			3'd0: r = 4'd4;
			3'd1: r = 4'd2;
			3'd2: r = 4'd3;
			3'd3: r = 4'd7;
			3'd4: r = 4'd6;
			3'd5: r = 4'd1;
			3'd6: r = 4'd8;
			default: r = 4'd5;
		endcase
		return r;
	endfunction

	function automatic logic [DW-1:0] opp_dir(input logic [DW-1:0] d);
		logic [DW-1:0] r;
		case (d)
			4'd1: r = 4'd3;
			4'd2: r = 4'd4;
			4'd3: r = 4'd1;
			4'd4: r = 4'd2;
			4'd5: r = 4'd7;
			4'd6: r = 4'd8;
			4'd7: r = 4'd5;
			4'd8: r = 4'd6;
			default: r = 4'd0;
		endcase
		return r;
	endfunction

	function automatic logic signed [1:0] nb_di(input logic [2:0] k);
		logic signed [1:0] r;
		case (k)
			3'd0, 3'd1: r = 2'sd0;
			3'd2, 3'd3, 3'd4: r = -2'sd1;
			default: r = 2'sd1;
		endcase
		return r;
	endfunction

	function automatic logic signed [1:0] nb_dj(input logic [2:0] k);
		logic signed [1:0] r;
		case (k)
			3'd0, 3'd3, 3'd6: r = -2'sd1;
			3'd2, 3'd5: r = 2'sd0;
			default: r = 2'sd1;
		endcase
		return r;
	endfunction
endpackage

/* rtl/core/cblf_link_gen.sv */
// Link generator: fluid test and serial emission of solid neighbor links
`timescale 1ns / 1ps
module cblf_link_gen (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic signed [cblf_pkg::CW-1:0] point_x,
	input  logic signed [cblf_pkg::CW-1:0] point_y,
	input  logic [10:0]                    radius_n,
	input  logic [11:0]                    center_x,
	input  logic [11:0]                    center_y,
	input  logic                           offset_en,
	output logic                           lk_valid,
	input  logic                           lk_ready,
	output cblf_pkg::link_t                lk
);
	import cblf_pkg::*;

	// stage 1: squares and solid mask
	logic                 v_s1;
	logic signed [CW-1:0] x_s1, y_s1;
	logic [24:0]          r2_s1;
	logic [24:0]          d2_s1;
	logic [OW-1:0]        ox_s1, oy_s1;
	// stage 2: mask held while links are emitted
	logic                 v_s2;
	logic [NNB-1:0]       mask_s2;
	logic signed [CW-1:0] x_s2, y_s2;
	logic [24:0]          c_s2;
	logic [OW-1:0]        ox_s2, oy_s2;
	logic [NNB-1:0]       solid_s1;

	logic signed [11:0] r_c;
	logic [2:0]         pick;
	logic [NNB-1:0]     rest;
	logic               adv2, adv1, take2;

	assign r_c = $signed({1'b0, radius_n}) - 12'sd1;

	// squared distance of each neighbor, compared to R^2 at stage 1
	always_comb begin
		for (int k = 0; k < NNB; k++) begin
			logic signed [CW+1:0] sx, sy;
			logic [26:0] s2;
			sx = (CW+2)'(x_s1) + (CW+2)'(nb_di(3'(k)));
			sy = (CW+2)'(y_s1) + (CW+2)'(nb_dj(3'(k)));
			s2 = 27'(sx) * 27'(sx) + 27'(sy) * 27'(sy);
			solid_s1[k] = s2 <= {2'b0, r2_s1};
		end
	end

	always_comb begin
		pick = 3'd0;
		for (int k = NNB-1; k >= 0; k--) begin
			if (mask_s2[k]) pick = 3'(k);
		end
		rest = mask_s2 & ~(NNB'(1) << pick);
	end

	assign lk_valid = v_s2 && (mask_s2 != '0);
	assign take2    = lk_valid && lk_ready;
	assign adv2     = !v_s2 || (mask_s2 == '0) || (take2 && rest == '0);
	assign adv1     = !v_s1 || adv2;
	assign in_ready = adv1;

	always_comb begin
		lk.dir  = nb_dir(pick);
		lk.back = opp_dir(nb_dir(pick));
		lk.di   = nb_di(pick);
		lk.dj   = nb_dj(pick);
		lk.x    = x_s2;
		lk.y    = y_s2;
		lk.ox   = ox_s2;
		lk.oy   = oy_s2;
		lk.c    = c_s2;
		lk.last = (rest == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			mask_s2 <= '0;
		end else begin
			if (adv1) v_s1 <= in_valid;
			if (adv2) begin
				v_s2 <= v_s1;
				mask_s2 <= (v_s1 && d2_s1 >= r2_s1) ? solid_s1 : '0;
			end else if (take2) begin
				mask_s2 <= rest;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && in_valid) begin
			x_s1  <= point_x;
			y_s1  <= point_y;
			r2_s1 <= 25'(25'(r_c) * 25'(r_c));
			d2_s1 <= 25'(point_x) * 25'(point_x)
				+ 25'(point_y) * 25'(point_y);
			ox_s1 <= offset_en ? OW'(center_x) : '0;
			oy_s1 <= offset_en ? OW'(center_y) : '0;
		end
		if (adv2 && v_s1) begin
			x_s2  <= x_s1;
			y_s2  <= y_s1;
			c_s2  <= d2_s1 - r2_s1;
			ox_s2 <= ox_s1;
			oy_s2 <= oy_s1;
		end
	end

	a_emit_needs_mask: assert property (@(posedge clk) disable iff (!arst_n)
		lk_valid |-> mask_s2[pick]) else $error("emitted link not in mask");
	a_rest_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(take2 && rest != '0) |=> $countones(mask_s2) == $countones($past(mask_s2)) - 1)
		else $error("mask did not shrink by one");
	a_no_intake_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && v_s2 && mask_s2 != '0 && !take2) |-> !in_ready)
		else $error("intake while stage two busy");
endmodule

/* rtl/core/cblf_isqrt.sv */
// Pipelined fixed point square root, several digits per stage with flow control
`timescale 1ns / 1ps
module cblf_isqrt #(
	parameter int FRAC_BITS = cblf_pkg::FRAC_BITS_DEF,
	parameter int DIN_W     = 28,
	parameter int TAG_W     = 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [DIN_W-1:0]                     din,
	input  logic [TAG_W-1:0]                     tag_in,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [(DIN_W+1)/2+FRAC_BITS-1:0]     root,
	output logic                                 exact,
	output logic [TAG_W-1:0]                     tag_out
);
	localparam int HD    = (DIN_W + 1) / 2;
	localparam int ND    = HD + FRAC_BITS;
	localparam int PAD_W = 2 * HD;
	localparam int RW    = ND + 2;
	localparam int PER   = 6;
	localparam int NST   = (ND + PER - 1) / PER;

	logic [NST:0]           v;
	logic [PAD_W-1:0]       dd  [NST+1];
	logic [RW-1:0]          rem [NST+1];
	logic [ND-1:0]          rt  [NST+1];
	logic [TAG_W-1:0]       tg  [NST+1];
	logic [NST:0]           adv;

	assign v[0]   = in_valid;
	assign dd[0]  = PAD_W'(din);
	assign rem[0] = '0;
	assign rt[0]  = '0;
	assign tg[0]  = tag_in;

	assign adv[NST] = !v[NST] || out_ready;
	for (genvar s = NST-1; s >= 0; s--) begin : g_adv
		assign adv[s] = !v[s+1] || adv[s+1];
	end
	assign in_ready = adv[0];

	for (genvar s = 0; s < NST; s++) begin : g_st
		logic [RW-1:0] rn;
		logic [ND-1:0] qn;
		always_comb begin
			logic [RW-1:0] tr, r2;
			logic [1:0] bits;
			rn = rem[s];
			qn = rt[s];
			for (int p = s*PER; p < s*PER + PER; p++) begin
				if (p < ND) begin
					bits = (p < HD) ? dd[s][PAD_W-1-2*p -: 2] : 2'b00;
					r2 = {rn[RW-3:0], bits};
					tr = {qn[RW-3:0], 2'b01};
					if (r2 >= tr) begin
						rn = r2 - tr;
						qn = {qn[ND-2:0], 1'b1};
					end else begin
						rn = r2;
						qn = {qn[ND-2:0], 1'b0};
					end
				end
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v[s+1] <= 1'b0;
			else if (adv[s]) v[s+1] <= v[s];
		end
		always_ff @(posedge clk) begin
			if (adv[s] && v[s]) begin
				dd[s+1]  <= dd[s];
				rem[s+1] <= rn;
				rt[s+1]  <= qn;
				tg[s+1]  <= tg[s];
			end
		end
	end

	assign out_valid = v[NST];
	assign root      = rt[NST];
	assign exact     = rem[NST] == '0;
	assign tag_out   = tg[NST];
endmodule

/* rtl/core/cblf_frac.sv */
// Wall fraction pipeline: discriminant, square root, root choice and division by shift
`timescale 1ns / 1ps
module cblf_frac #(
	parameter int FRAC_BITS = cblf_pkg::FRAC_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   lk_valid,
	output logic                   lk_ready,
	input  cblf_pkg::link_t        lk,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [cblf_pkg::DW-1:0] link_dir,
	output logic [cblf_pkg::DW-1:0] back_dir,
	output logic [cblf_pkg::OW-1:0] fluid_x,
	output logic [cblf_pkg::OW-1:0] fluid_y,
	output logic [cblf_pkg::OW-1:0] solid_x,
	output logic [cblf_pkg::OW-1:0] solid_y,
	output logic [cblf_pkg::OW-1:0] far_x,
	output logic [cblf_pkg::OW-1:0] far_y,
	output logic [cblf_pkg::FW-1:0] wall_fraction,
	output logic                   last
);
	import cblf_pkg::*;

	localparam int BW   = 15;                       // |b| <= 2*(2048+2048)
	localparam int DIN  = 29;                       // d = b^2 - 4ac, nonneg after clamp
	localparam int RTW  = (DIN + 1) / 2 + FRAC_BITS;
	localparam int NW   = BW + FRAC_BITS + 2;       // signed numerator width
	localparam int TAGW = $bits(link_t);

	// stage a: discriminant
	logic                 va_q;
	link_t                la_q;
	logic [DIN-1:0]       d_a;
	logic                 sq_ready, sq_valid, sq_exact;
	logic [RTW-1:0]       sq_root;
	logic [TAGW-1:0]      sq_tag;
	link_t                lq;
	logic signed [BW-1:0] b_c;
	logic [1:0]           a_c;
	logic                 dv_ready;
	logic                 vo_q;

	logic signed [BW-1:0] b_n;
	logic signed [DIN+1:0] d_n;
	logic [1:0]           a_n;

	always_comb begin
		a_n = (lk.di != 0 && lk.dj != 0) ? 2'd2 : 2'd1;
		b_n = BW'(2 * (BW'(lk.x) * BW'(lk.di) + BW'(lk.y) * BW'(lk.dj)));
		d_n = (DIN+2)'(b_n) * (DIN+2)'(b_n)
			- (DIN+2)'({a_n, 2'b00}) * (DIN+2)'(lk.c);
	end

	assign lk_ready = !va_q || sq_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) va_q <= 1'b0;
		else if (lk_ready) va_q <= lk_valid;
	end
	always_ff @(posedge clk) begin
		if (lk_ready && lk_valid) begin
			la_q <= lk;
			d_a  <= d_n[DIN+1] ? '0 : DIN'(d_n);
		end
	end

	cblf_isqrt #(.FRAC_BITS(FRAC_BITS), .DIN_W(DIN), .TAG_W(TAGW)) u_sqrt (
		.clk(clk), .arst_n(arst_n),
		.in_valid(va_q), .in_ready(sq_ready), .din(d_a), .tag_in(la_q),
		.out_valid(sq_valid), .out_ready(dv_ready), .root(sq_root),
		.exact(sq_exact), .tag_out(sq_tag)
	);

	// root choice, then division by 2a (2 or 4) as a shift
	logic signed [NW+RTW:0] np, nm, top, num;

	always_comb begin
		lq  = link_t'(sq_tag);
		a_c = (lq.di != 0 && lq.dj != 0) ? 2'd2 : 2'd1;
		b_c = BW'(2 * (BW'(lq.x) * BW'(lq.di) + BW'(lq.y) * BW'(lq.dj)));
		top = (NW+RTW+1)'(a_c) <<< (FRAC_BITS + 1);
		np  = -((NW+RTW+1)'(b_c) <<< FRAC_BITS) + (NW+RTW+1)'(sq_root);
		nm  = -((NW+RTW+1)'(b_c) <<< FRAC_BITS) - (NW+RTW+1)'(sq_root)
			- (sq_exact ? '0 : (NW+RTW+1)'(1));
		if (np >= 0 && np <= top) num = np;
		else if (nm >= 0 && nm <= top) num = nm;
		else num = '0;
	end

	assign dv_ready = !vo_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vo_q <= 1'b0;
		else if (dv_ready) vo_q <= sq_valid;
	end
	always_ff @(posedge clk) begin
		if (dv_ready && sq_valid) begin
			link_dir <= lq.dir;
			back_dir <= lq.back;
			fluid_x  <= OW'(lq.x) + lq.ox;
			fluid_y  <= OW'(lq.y) + lq.oy;
			solid_x  <= OW'(lq.x) + OW'(lq.di) + lq.ox;
			solid_y  <= OW'(lq.y) + OW'(lq.dj) + lq.oy;
			far_x    <= OW'(lq.x) - OW'(lq.di) + lq.ox;
			far_y    <= OW'(lq.y) - OW'(lq.dj) + lq.oy;
			wall_fraction <= (a_c == 2'd2) ? FW'(num >>> 2) : FW'(num >>> 1);
			last     <= lq.last;
		end
	end
	assign out_valid = vo_q;

	a_frac_range: assert property (@(posedge clk) disable iff (!arst_n)
		vo_q |-> wall_fraction <= FW'(1 << FRAC_BITS)) else $error("fraction above one");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(vo_q && !out_ready) |=> vo_q && $stable(wall_fraction)) else $error("output lost");
	a_back: assert property (@(posedge clk) disable iff (!arst_n)
		vo_q |-> back_dir == opp_dir(link_dir)) else $error("bad back code");
endmodule

/* rtl/core/circle_boundary_link_fraction_unit.sv */
// Top level: configuration registers and the link and fraction pipelines
// An accepted point passes two link stages, one discriminant stage, six square root stages
// and one output register before its first result appears.
// Throughput: one link result per cycle unless stalled; a point with k solid neighbors
// holds intake until the link emitter has sent its k links, one per cycle when accepted.
// Reset clears all valid bits and loads radius_n=1, centers 0, center offset enabled.
`timescale 1ns / 1ps
module circle_boundary_link_fraction_unit #(
	parameter int FRAC_BITS = cblf_pkg::FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [1:0]                     cfg_index,
	input  logic [11:0]                    cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic signed [cblf_pkg::CW-1:0] point_x,
	input  logic signed [cblf_pkg::CW-1:0] point_y,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [cblf_pkg::DW-1:0]        link_dir,
	output logic [cblf_pkg::DW-1:0]        back_dir,
	output logic [cblf_pkg::OW-1:0]        fluid_x,
	output logic [cblf_pkg::OW-1:0]        fluid_y,
	output logic [cblf_pkg::OW-1:0]        solid_x,
	output logic [cblf_pkg::OW-1:0]        solid_y,
	output logic [cblf_pkg::OW-1:0]        far_x,
	output logic [cblf_pkg::OW-1:0]        far_y,
	output logic [cblf_pkg::FW-1:0]        wall_fraction,
	output logic                           last
);
	import cblf_pkg::*;

	logic [10:0] radius_q;
	logic [11:0] cx_q, cy_q;
	logic        addc_q;
	logic        lk_valid, lk_ready;
	link_t       lk;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= 11'd1;
			cx_q     <= '0;
			cy_q     <= '0;
			addc_q   <= 1'b1;
		end else if (cfg_valid) begin
			case (reg_idx_t'(cfg_index))
				REG_RADIUS:   radius_q <= cfg_data[10:0];
				REG_CENTER_X: cx_q     <= cfg_data;
				REG_CENTER_Y: cy_q     <= cfg_data;
				REG_ADD_CTR:  addc_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	cblf_link_gen u_gen (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.point_x(point_x), .point_y(point_y),
		.radius_n(radius_q), .center_x(cx_q), .center_y(cy_q), .offset_en(addc_q),
		.lk_valid(lk_valid), .lk_ready(lk_ready), .lk(lk)
	);

	cblf_frac #(.FRAC_BITS(FRAC_BITS)) u_frac (
		.clk(clk), .arst_n(arst_n),
		.lk_valid(lk_valid), .lk_ready(lk_ready), .lk(lk),
		.out_valid(out_valid), .out_ready(out_ready),
		.link_dir(link_dir), .back_dir(back_dir),
		.fluid_x(fluid_x), .fluid_y(fluid_y),
		.solid_x(solid_x), .solid_y(solid_y),
		.far_x(far_x), .far_y(far_y),
		.wall_fraction(wall_fraction), .last(last)
	);
endmodule

/* sim/tb_circle_boundary_link_fraction_unit.sv */
// Testbench: circle boundary link fraction unit checked against a scoreboard predictor
`timescale 1ns / 1ps
module tb_circle_boundary_link_fraction_unit;
	import cblf_pkg::*;

	typedef struct {
		logic [DW-1:0] dir;
		logic [DW-1:0] back;
		logic [OW-1:0] fx, fy, sx, sy, mx, my;
		logic [FW-1:0] frac;
		logic          fin;
	} link_res_t;

	class link_scoreboard;
		link_res_t pending[$];
		int        errors;
		longint    radius_n = 1, cx = 0, cy = 0;
		bit        add_ctr = 1;

		task report(string what, longint got, longint want);
			$display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
			errors++;
		endtask

		function longint unsigned root_q(longint unsigned d, output bit exact);
			longint unsigned rem, root, bits, trial;
			rem = 0;
			root = 0;
			for (int p = 0; p < 32 + FRAC_BITS_DEF; p++) begin
				bits = (p < 32) ? ((d >> (62 - 2 * p)) & 3) : 0;
				rem = (rem << 2) | bits;
				trial = (root << 2) | 1;
				if (rem >= trial) begin
					rem -= trial;
					root = (root << 1) | 1;
				end else begin
					root = root << 1;
				end
			end
			exact = (rem == 0);
			return root;
		endfunction

		function longint fraction(longint a, longint b, longint c);
			longint sc, den, top, d, s, sup, np, nm;
			bit exact;
			sc = longint'(1) << FRAC_BITS_DEF;
			den = 2 * a;
			top = den * sc;
			d = b * b - 4 * a * c;
			if (d < 0)
				d = 0;
			s = root_q(d, exact);
			sup = exact ? s : s + 1;
			np = -b * sc + s;
			nm = -b * sc - sup;
			if (np >= 0 && np <= top)
				return np / den;
			if (nm >= 0 && nm <= top)
				return nm / den;
			return 0;
		endfunction

		function void note(logic signed [CW-1:0] px, logic signed [CW-1:0] py);
			longint x, y, r, r2, ox, oy, c, di, dj, sx, sy;
			int n;
			link_res_t e;
			x = px;
			y = py;
			r = radius_n - 1;
			r2 = r * r;
			ox = add_ctr ? cx : 0;
			oy = add_ctr ? cy : 0;
			c = x * x + y * y - r2;
			n = 0;
			if (c < 0)
				return;
			for (int k = 0; k < NNB; k++) begin
				case (k)
					0: begin di = 0; dj = -1; e.dir = 4'd4; end
					1: begin di = 0; dj = 1; e.dir = 4'd2; end
					2: begin di = -1; dj = 0; e.dir = 4'd3; end
					3: begin di = -1; dj = -1; e.dir = 4'd7; end
					4: begin di = -1; dj = 1; e.dir = 4'd6; end
					5: begin di = 1; dj = 0; e.dir = 4'd1; end
					6: begin di = 1; dj = -1; e.dir = 4'd8; end
					default: begin di = 1; dj = 1; e.dir = 4'd5; end
				endcase
				sx = x + di;
				sy = y + dj;
				if (sx * sx + sy * sy > r2)
					continue;
				e.back = (e.dir > 4) ? ((e.dir - 5 + 2) % 4 + 5) : ((e.dir - 1 + 2) % 4 + 1);
				e.fx = OW'(x + ox);
				e.fy = OW'(y + oy);
				e.sx = OW'(sx + ox);
				e.sy = OW'(sy + oy);
				e.mx = OW'(x - di + ox);
				e.my = OW'(y - dj + oy);
				e.frac = FW'(fraction(di * di + dj * dj, 2 * (x * di + y * dj), c));
				e.fin = 0;
				pending.insert(pending.size(), e);
				n++;
			end
			if (n > 0)
				pending[pending.size() - 1].fin = 1;
		endfunction

		task check(link_res_t g);
			link_res_t e;
			if (pending.size() == 0) begin
				report("unexpected transaction", g.dir, 0);
				return;
			end
			e = pending.pop_front();
			if (g.dir !== e.dir) report("link_dir", g.dir, e.dir);
			if (g.back !== e.back) report("back_dir", g.back, e.back);
			if (g.fx !== e.fx) report("fluid_x", g.fx, e.fx);
			if (g.fy !== e.fy) report("fluid_y", g.fy, e.fy);
			if (g.sx !== e.sx) report("solid_x", g.sx, e.sx);
			if (g.sy !== e.sy) report("solid_y", g.sy, e.sy);
			if (g.mx !== e.mx) report("far_x", g.mx, e.mx);
			if (g.my !== e.my) report("far_y", g.my, e.my);
			if (g.frac !== e.frac) report("wall_fraction", g.frac, e.frac);
			if (g.fin !== e.fin) report("last", g.fin, e.fin);
		endtask
	endclass

	logic                 clk = 0;
	logic                 arst_n = 0;
	logic                 cfg_valid = 0;
	logic                 cfg_ready;
	logic [1:0]           cfg_index = REG_RADIUS;
	logic [11:0]          cfg_data = 0;
	logic                 in_valid = 0;
	logic                 in_ready;
	logic signed [CW-1:0] point_x = 0;
	logic signed [CW-1:0] point_y = 0;
	logic                 out_valid;
	logic                 out_ready = 0;
	logic [DW-1:0]        link_dir, back_dir;
	logic [OW-1:0]        fluid_x, fluid_y, solid_x, solid_y, far_x, far_y;
	logic [FW-1:0]        wall_fraction;
	logic                 last;

	link_scoreboard sb = new();
	int cyc = 0;
	int stall = 0;
	int burst_left = 0;

	circle_boundary_link_fraction_unit uut (.*);

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	always @(posedge clk) begin
		link_res_t g;
		if (in_valid && in_ready)
			sb.note(point_x, point_y);
		if (out_valid && out_ready) begin
			g.dir = link_dir;
			g.back = back_dir;
			g.fx = fluid_x;
			g.fy = fluid_y;
			g.sx = solid_x;
			g.sy = solid_y;
			g.mx = far_x;
			g.my = far_y;
			g.frac = wall_fraction;
			g.fin = last;
			sb.check(g);
		end
	end

	// receiver stall pattern, stepping through four modes in turn
	always @(posedge clk) begin
		cyc <= cyc + 1;
		case ((cyc / 64) % 4)
			0: out_ready <= 1;
			1: out_ready <= ($urandom_range(1, 0) == 1);
			2: out_ready <= ($urandom_range(3, 0) == 0);
			default: begin
				if (stall > 0) begin
					stall <= stall - 1;
					out_ready <= 0;
				end else begin
					stall <= $urandom_range(12, 0);
					out_ready <= 1;
				end
			end
		endcase
	end

	task write_reg(reg_idx_t idx, int value);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= 12'(value);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		case (idx)
			REG_RADIUS: sb.radius_n = value;
			REG_CENTER_X: sb.cx = value;
			REG_CENTER_Y: sb.cy = value;
			default: sb.add_ctr = value;
		endcase
		@(posedge clk);
	endtask

	task drain;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task pause_input;
		if (burst_left != 0)
			in_valid <= 0;
		burst_left = 0;
	endtask

	task send_point(int x, int y);
		if (burst_left == 0) begin
			repeat ($urandom_range(6, 1)) @(posedge clk);
			burst_left = $urandom_range(8, 1);
		end
		in_valid <= 1;
		point_x <= CW'(x);
		point_y <= CW'(y);
		do @(posedge clk); while (!in_ready);
		burst_left--;
		if (burst_left == 0)
			in_valid <= 0;
	endtask

	task random_point(int r);
		int x, y, v;
		if ($urandom_range(3, 0) == 0 || r < 1) begin
			send_point($urandom_range(4095, 0) - 2048, $urandom_range(4095, 0) - 2048);
		end else begin
			x = $urandom_range(2 * r + 2, 0) - r - 1;
			v = r * r - x * x;
			y = (v > 0) ? int'($sqrt(real'(v))) : 0;
			y = y + $urandom_range(2, 0) - 1;
			if ($urandom_range(1, 0))
				y = -y;
			send_point(x, y);
		end
	endtask

	task run_phase(int rad, int cx, int cy, int add, int count);
		pause_input();
		drain();
		write_reg(REG_RADIUS, rad);
		write_reg(REG_CENTER_X, cx);
		write_reg(REG_CENTER_Y, cy);
		write_reg(REG_ADD_CTR, add);
		for (int i = 0; i < count; i++) begin
			if (i == count / 2) begin
				pause_input();
				drain();
			end
			random_point(rad - 1);
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		write_reg(REG_RADIUS, 5);
		write_reg(REG_CENTER_X, 4095);
		write_reg(REG_CENTER_Y, 4095);
		write_reg(REG_ADD_CTR, 1);
		send_point(-2048, -2048);
		send_point(2047, 2047);
		send_point(0, 0);
		send_point(4, 0);
		send_point(5, 0);
		send_point(0, -4);
		send_point(3, 3);
		send_point(-3, 3);
		send_point(-4, -1);
		send_point(2, -4);
		send_point(-1, 5);
		send_point(1024, -1024);
		send_point(-1024, 1024);
		send_point(10, 10);
		run_phase(1024, 4095, 4095, 1, 25);
		run_phase(0, 100, 200, 0, 20);
		run_phase(1, 0, 0, 1, 20);
		run_phase(300, 2048, 17, 0, 25);
		run_phase(2047, 4095, 0, 1, 25);
		run_phase(12, 7, 3000, 1, 25);
		pause_input();
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
		if (sb.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#4000000;
		$display("Simulation FAILED");
		$finish;
	end
endmodule

/* sim.f */
rtl/core/cblf_pkg.sv
rtl/core/cblf_link_gen.sv
rtl/core/cblf_isqrt.sv
rtl/core/cblf_frac.sv
rtl/core/circle_boundary_link_fraction_unit.sv
sim/tb_circle_boundary_link_fraction_unit.sv
